// ===== rtl/esscl_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// esscl_pkg: shared types and constants of the single-cycle length unit
// Command codes, the controller command bundle and the datapath status
// bundle.
// ---------------------------------------------------------------------------
package esscl_pkg;

   // command codes of an input word
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // width of the length result and the shortest cycle that counts
   localparam int LEN_W     = 7;
   localparam int MIN_CYCLE = 3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_write;
      logic query_start;
      logic scan_step;
      logic walk_start;
      logic walk_step;
      logic res_zero;
      logic res_walk;
   } esscl_ctl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_last;
      logic check_ok;
      logic walk_end;
   } esscl_status_type;

endpackage : esscl_pkg
`default_nettype wire

// ===== rtl/esscl_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// esscl_datapath: edge table, degree scan and cycle walk
// Holds the edge endpoint table, scans every slot one edge per cycle, builds
// degree vectors and per-vertex neighbor tables from the subset's edges,
// then walks the cycle one vertex per cycle.
// ---------------------------------------------------------------------------
module esscl_datapath
   import esscl_pkg::*;
#(
   parameter int MAX_EDGES    = 64,
   parameter int MAX_VERTICES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire esscl_ctl_type    ctl,
   output esscl_status_type      status,
   input  wire logic [5:0]       req_edge_index,
   input  wire logic [5:0]       req_end_a,
   input  wire logic [5:0]       req_end_b,
   input  wire logic [63:0]      req_edge_set,
   output logic [LEN_W-1:0]      rsp_cycle_length
);

   localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW    = $clog2(MAX_EDGES + 1);
   localparam int ENT_W = EW + VW;

   // edge table, endpoint a in the low half
   logic [2*VW-1:0]   edge_mem [MAX_EDGES];
   logic [2*VW-1:0]   rd_edge_ff;
   logic              edge_we;

   // neighbor tables: {edge index, other vertex}, two slots per side
   logic [ENT_W-1:0]  nbr_a0_mem [MAX_VERTICES];
   logic [ENT_W-1:0]  nbr_a1_mem [MAX_VERTICES];
   logic [ENT_W-1:0]  nbr_b0_mem [MAX_VERTICES];
   logic [ENT_W-1:0]  nbr_b1_mem [MAX_VERTICES];
   logic [ENT_W-1:0]  rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;
   logic [VW-1:0]     nbr_addr;

   // scan state
   logic [MAX_EDGES-1:0]    set_ff;
   logic [EW-1:0]           scan_idx_ff;
   logic [EW-1:0]           proc_idx_ff;
   logic                    proc_bit_ff;
   logic                    proc_live_ff;
   logic [CW-1:0]           ne_ff;
   logic                    loop_ff;
   logic                    first_ff;
   logic [VW-1:0]           start_v_ff;
   logic [MAX_VERTICES-1:0] seen1_ff, seen2_ff, over_ff;
   logic [MAX_VERTICES-1:0] cnt_a1_ff, cnt_a2_ff, cnt_b1_ff, cnt_b2_ff;

   // walk state
   logic [VW-1:0]     cur_ff;
   logic [EW-1:0]     prev_edge_ff;
   logic              first_step_ff;
   logic [CW-1:0]     steps_ff;
   logic [CW-1:0]     steps_in;
   logic [LEN_W-1:0]  res_ff;

   logic [VW-1:0]           pa, pb;
   logic [MAX_VERTICES-1:0] ma, mb, mab;
   logic                    proc_take;
   logic [ENT_W-1:0]        ent0, ent1, chosen;
   logic [VW-1:0]           next_v;
   logic                    walk_pass;

   // load address and range filter
   assign edge_we = ctl.load_write && (int'(req_edge_index) < MAX_EDGES)
                    && (int'(req_end_a) < MAX_VERTICES)
                    && (int'(req_end_b) < MAX_VERTICES);

   // edge table write and scan read
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[req_edge_index[EW-1:0]] <= {req_end_b[VW-1:0], req_end_a[VW-1:0]};
      end
      rd_edge_ff <= edge_mem[scan_idx_ff];
   end

   // edge under scan
   assign pa        = rd_edge_ff[VW-1:0];
   assign pb        = rd_edge_ff[2*VW-1:VW];
   assign ma        = MAX_VERTICES'(1) << pa;
   assign mb        = MAX_VERTICES'(1) << pb;
   assign mab       = ma | mb;
   assign proc_take = proc_live_ff && proc_bit_ff;

   // scan control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         proc_live_ff <= 1'b0;
      end else begin
         proc_live_ff <= ctl.scan_step;
      end
   end

   // scan pointer, degree vectors and subset bookkeeping
   always_ff @(posedge clock) begin
      if (ctl.query_start) begin
         set_ff      <= req_edge_set[MAX_EDGES-1:0];
         scan_idx_ff <= '0;
         ne_ff       <= '0;
         loop_ff     <= 1'b0;
         first_ff    <= 1'b1;
         seen1_ff    <= '0;
         seen2_ff    <= '0;
         over_ff     <= '0;
         cnt_a1_ff   <= '0;
         cnt_a2_ff   <= '0;
         cnt_b1_ff   <= '0;
         cnt_b2_ff   <= '0;
      end else begin
         if (ctl.scan_step) begin
            scan_idx_ff <= scan_idx_ff + EW'(1);
            proc_idx_ff <= scan_idx_ff;
            proc_bit_ff <= set_ff[scan_idx_ff];
         end
         if (proc_take) begin
            ne_ff     <= ne_ff + CW'(1);
            over_ff   <= over_ff | (seen2_ff & mab);
            seen2_ff  <= seen2_ff | (seen1_ff & mab);
            seen1_ff  <= seen1_ff | mab;
            cnt_a2_ff <= cnt_a2_ff | (cnt_a1_ff & ma);
            cnt_a1_ff <= cnt_a1_ff | ma;
            cnt_b2_ff <= cnt_b2_ff | (cnt_b1_ff & mb);
            cnt_b1_ff <= cnt_b1_ff | mb;
            if (pa == pb) begin
               loop_ff <= 1'b1;
            end
            if (first_ff) begin
               start_v_ff <= pa;
               first_ff   <= 1'b0;
            end
         end
      end
   end

   // neighbor table writes during the scan
   always_ff @(posedge clock) begin
      if (proc_take) begin
         if (cnt_a1_ff[pa]) begin
            nbr_a1_mem[pa] <= {proc_idx_ff, pb};
         end else begin
            nbr_a0_mem[pa] <= {proc_idx_ff, pb};
         end
         if (cnt_b1_ff[pb]) begin
            nbr_b1_mem[pb] <= {proc_idx_ff, pa};
         end else begin
            nbr_b0_mem[pb] <= {proc_idx_ff, pa};
         end
      end
   end

   // neighbor table reads, one vertex per cycle
   assign nbr_addr = ctl.walk_start ? start_v_ff : next_v;

   always_ff @(posedge clock) begin
      rd_a0_ff <= nbr_a0_mem[nbr_addr];
      rd_a1_ff <= nbr_a1_mem[nbr_addr];
      rd_b0_ff <= nbr_b0_mem[nbr_addr];
      rd_b1_ff <= nbr_b1_mem[nbr_addr];
   end

   // pick both edges of the current vertex, then whichever was not just used
   always_comb begin
      if (cnt_a2_ff[cur_ff]) begin
         ent0 = rd_a0_ff;
         ent1 = rd_a1_ff;
      end else if (cnt_b2_ff[cur_ff]) begin
         ent0 = rd_b0_ff;
         ent1 = rd_b1_ff;
      end else begin
         ent0 = rd_a0_ff;
         ent1 = rd_b0_ff;
      end
      if (first_step_ff || (ent0[ENT_W-1:VW] != prev_edge_ff)) begin
         chosen = ent0;
      end else begin
         chosen = ent1;
      end
   end

   assign next_v    = chosen[VW-1:0];
   assign steps_in  = steps_ff + CW'(1);
   assign walk_pass = (next_v == start_v_ff) && (steps_in == ne_ff);

   // walk registers
   always_ff @(posedge clock) begin
      if (ctl.walk_start) begin
         cur_ff        <= start_v_ff;
         first_step_ff <= 1'b1;
         steps_ff      <= '0;
      end else if (ctl.walk_step) begin
         cur_ff        <= next_v;
         prev_edge_ff  <= chosen[ENT_W-1:VW];
         first_step_ff <= 1'b0;
         steps_ff      <= steps_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (ctl.res_zero) begin
         res_ff <= '0;
      end else if (ctl.res_walk) begin
         res_ff <= walk_pass ? LEN_W'(ne_ff) : '0;
      end
   end

   // status toward the controller
   assign status.scan_last = (scan_idx_ff == EW'(MAX_EDGES - 1));
   assign status.check_ok  = !loop_ff && (over_ff == '0) && (seen1_ff == seen2_ff)
                             && (ne_ff >= CW'(MIN_CYCLE));
   assign status.walk_end  = (next_v == start_v_ff) || (steps_in == ne_ff);

   assign rsp_cycle_length = res_ff;

endmodule : esscl_datapath
`default_nettype wire

// ===== rtl/esscl_control.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// esscl_control: sequencer of the single-cycle length unit
// Accepts load words and steps a query through edge scan, drain, degree
// check and, if the check passes, cycle walk, and issues the result strobe.
// ---------------------------------------------------------------------------
module esscl_control
   import esscl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             req_cmd,
   input  wire esscl_status_type status,
   output esscl_ctl_type         ctl,
   output logic                  busy,
   output logic                  rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && start;

   // datapath commands
   always_comb begin
      ctl             = '0;
      ctl.load_write  = accept && (req_cmd == CMD_LOAD);
      ctl.query_start = accept && (req_cmd == CMD_TEST);
      ctl.scan_step   = (state_ff == ST_SCAN);
      ctl.walk_start  = (state_ff == ST_CHECK) && status.check_ok;
      ctl.res_zero    = (state_ff == ST_CHECK) && !status.check_ok;
      ctl.walk_step   = (state_ff == ST_WALK);
      ctl.res_walk    = (state_ff == ST_WALK) && status.walk_end;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start && (req_cmd == CMD_TEST)) begin
                  state_ff <= ST_SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SCAN: begin
               rsp_valid_ff <= 1'b0;
               if (status.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_CHECK;
            end
            ST_CHECK: begin
               if (status.check_ok) begin
                  state_ff     <= ST_WALK;
                  rsp_valid_ff <= 1'b0;
               end else begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_WALK: begin
               rsp_valid_ff <= status.walk_end;
               if (status.walk_end) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule : esscl_control
`default_nettype wire

// ===== rtl/edge_set_single_cycle_length_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// edge_set_single_cycle_length_unit: single-cycle test of an edge subset
// Loads an edge endpoint table and answers subset queries with the length
// of the single simple cycle they form, or 0.
// ---------------------------------------------------------------------------
// A load word never raises busy, so loads can follow each other every
// cycle while the unit is idle. A query word raises busy for the edge scan,
// the drain state and the degree check, and, when the degree check passes,
// for the cycle walk, up to one step per edge of the subset. The scan reads
// the edge table one entry per cycle; the walk reads the per-vertex neighbor
// tables one vertex per cycle. The result is on rsp_cycle_length for the
// single cycle in which rsp_valid is high, the first cycle with busy low;
// there is no back-pressure, and a new word may be started in that same
// cycle. A query that touches a never loaded edge slot gives an undefined
// length.
// ---------------------------------------------------------------------------
module edge_set_single_cycle_length_unit
   import esscl_pkg::*;
#(
   parameter int MAX_EDGES    = 64,
   parameter int MAX_VERTICES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_cmd,
   input  wire logic [5:0]       req_edge_index,
   input  wire logic [5:0]       req_end_a,
   input  wire logic [5:0]       req_end_b,
   input  wire logic [63:0]      req_edge_set,
   output logic                  rsp_valid,
   output logic [LEN_W-1:0]      rsp_cycle_length
);

   esscl_ctl_type    ctl;
   esscl_status_type status;

   // sequencer
   esscl_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .status    (status),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // tables, scan and walk
   esscl_datapath #(
      .MAX_EDGES    (MAX_EDGES),
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .status           (status),
      .req_edge_index   (req_edge_index),
      .req_end_a        (req_end_a),
      .req_end_b        (req_end_b),
      .req_edge_set     (req_edge_set),
      .rsp_cycle_length (rsp_cycle_length)
   );

   // result strobe only comes once the query has released busy
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted query raises busy in the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_TEST)) |=> busy)
      else $error("query accepted but busy not raised");

   // a load word never occupies the unit
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_LOAD)) |=> !busy)
      else $error("load word raised busy");

   // a nonzero length is never shorter than a triangle
   a_len_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_cycle_length != '0)) |-> (rsp_cycle_length >= LEN_W'(MIN_CYCLE)))
      else $error("cycle length below minimum");

endmodule : edge_set_single_cycle_length_unit
`default_nettype wire

// ===== bench/edge_set_single_cycle_length_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// edge_set_single_cycle_length_unit_tb: bench for the single-cycle length unit
// Fills the edge table with load words and sends subset queries. Most of them
// are random simple rings, and some are opened, merged, spoiled or given a
// stray edge. Each length that comes back is checked against an in-bench
// predictor of the cycle test.
// ---------------------------------------------------------------------------
module edge_set_single_cycle_length_unit_tb;
   import esscl_pkg::*;

   localparam int N_SLOTS      = 64;
   localparam int RANDOM_WORDS = 1650;
   localparam int CALM_WORDS   = 150;
   localparam int DRAIN_CYCLES = 150;

   // one word as the sender drives it
   typedef struct {
      logic        cmd;
      logic [5:0]  slot;
      logic [5:0]  end_a;
      logic [5:0]  end_b;
      logic [63:0] subset;
   } edge_word_type;

   typedef struct packed {
      logic [5:0] b;
      logic [5:0] a;
   } edge_ends_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             start            = 1'b0;
   logic             busy;
   logic             req_cmd          = CMD_LOAD;
   logic [5:0]       req_edge_index   = '0;
   logic [5:0]       req_end_a        = '0;
   logic [5:0]       req_end_b        = '0;
   logic [63:0]      req_edge_set     = '0;
   logic             rsp_valid;
   logic [LEN_W-1:0] rsp_cycle_length;

   edge_word_type    pending_words [$];
   logic [LEN_W-1:0] expected_lengths [$];

   // predictor copy of the edge table, written as words are taken
   edge_ends_type loaded_ends [N_SLOTS];
   // slots the generator has loaded, so queries touch only loaded slots
   logic [63:0] plan_written = '0;
   logic [5:0]  slot_order [N_SLOTS];
   logic [5:0]  vert_order [N_SLOTS];

   edge_word_type    next_word;
   logic [LEN_W-1:0] want_length;
   logic             word_taken   = 1'b0;
   int               gap_left     = 0;
   int               words_driven = 0;
   int               words_planned = 0;
   int               words_taken  = 0;
   int               calm_mark    = 32'h7fff_ffff;
   int               load_count   = 0;
   int               query_count  = 0;
   int               cycle_hits   = 0;
   int               longest_hit  = 0;
   int               error_count  = 0;

   edge_set_single_cycle_length_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_edge_index   (req_edge_index),
      .req_end_a        (req_end_a),
      .req_end_b        (req_end_b),
      .req_edge_set     (req_edge_set),
      .rsp_valid        (rsp_valid),
      .rsp_cycle_length (rsp_cycle_length)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // length of the single simple cycle a subset forms, 0 if it is not one
   function automatic logic [LEN_W-1:0] single_cycle_length(input logic [63:0] subset);
      int unsigned n_edges;
      int unsigned degree [N_SLOTS];
      logic [63:0] touched;
      logic [63:0] reach;
      logic [63:0] prev_reach;
      logic [63:0] ends;
      logic        seeded;
      n_edges = $countones(subset);
      if (n_edges < MIN_CYCLE) return '0;
      touched = '0;
      reach   = '0;
      seeded  = 1'b0;
      foreach (degree[v]) degree[v] = 0;
      for (int e = 0; e < N_SLOTS; e++) begin
         if (subset[e]) begin
            if (loaded_ends[e].a == loaded_ends[e].b) return '0;
            degree[loaded_ends[e].a]++;
            degree[loaded_ends[e].b]++;
            ends = (64'd1 << loaded_ends[e].a) | (64'd1 << loaded_ends[e].b);
            touched |= ends;
            // the walk starts on the lowest edge of the subset
            if (!seeded) begin
               reach  = ends;
               seeded = 1'b1;
            end
         end
      end
      for (int v = 0; v < N_SLOTS; v++) begin
         if (touched[v] && degree[v] != 2) return '0;
      end
      // grow the lowest edge's component until it stops changing
      for (int pass = 0; pass < N_SLOTS; pass++) begin
         prev_reach = reach;
         for (int e = 0; e < N_SLOTS; e++) begin
            if (subset[e]) begin
               ends = (64'd1 << loaded_ends[e].a) | (64'd1 << loaded_ends[e].b);
               if ((ends & reach) != 0) reach |= ends;
            end
         end
         if (reach == prev_reach) break;
      end
      return (reach == touched) ? LEN_W'(n_edges) : '0;
   endfunction

   // queue a load word and note the slot as loaded
   task automatic plan_load(input logic [5:0] slot, input logic [5:0] a, input logic [5:0] b);
      edge_word_type w;
      w.cmd    = CMD_LOAD;
      w.slot   = slot;
      w.end_a  = a;
      w.end_b  = b;
      w.subset = {$urandom, $urandom};
      pending_words.push_back(w);
      plan_written[slot] = 1'b1;
      words_planned++;
   endtask

   // queue a query word, restricted to slots that were loaded
   task automatic plan_query(input logic [63:0] subset);
      edge_word_type w;
      w.cmd    = CMD_TEST;
      w.slot   = 6'($urandom);
      w.end_a  = 6'($urandom);
      w.end_b  = 6'($urandom);
      w.subset = subset & plan_written;
      pending_words.push_back(w);
      words_planned++;
   endtask

   // load a ring of len edges on random slots and vertices, random orientation
   task automatic plan_ring(input int len, output logic [63:0] ring, output logic [5:0] ring_slot);
      logic [5:0] tmp;
      int         j;
      for (int i = 0; i < N_SLOTS; i++) begin
         slot_order[i] = 6'(i);
         vert_order[i] = 6'(i);
      end
      for (int i = N_SLOTS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = slot_order[i];
         slot_order[i] = slot_order[j];
         slot_order[j] = tmp;
         j = $urandom_range(0, i);
         tmp = vert_order[i];
         vert_order[i] = vert_order[j];
         vert_order[j] = tmp;
      end
      ring = '0;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 1) == 1)
            plan_load(slot_order[k], vert_order[k], vert_order[(k + 1) % len]);
         else
            plan_load(slot_order[k], vert_order[(k + 1) % len], vert_order[k]);
         ring[slot_order[k]] = 1'b1;
      end
      ring_slot = slot_order[$urandom_range(0, len - 1)];
   endtask

   // driver: one word per handshake, random idle bursts until the calm tail
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !word_taken) begin
         // word not taken yet, hold it
      end else if (gap_left > 0) begin
         start    <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0 && words_driven < calm_mark &&
                   $urandom_range(0, 4) == 0) begin
         start    <= 1'b0;
         gap_left <= $urandom_range(0, 6);
      end else if (pending_words.size() != 0) begin
         next_word      = pending_words.pop_front();
         req_cmd        <= next_word.cmd;
         req_edge_index <= next_word.slot;
         req_end_a      <= next_word.end_a;
         req_end_b      <= next_word.end_b;
         req_edge_set   <= next_word.subset;
         start          <= 1'b1;
         words_driven   <= words_driven + 1;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check results, then step the predictor on a taken word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_lengths.size() == 0) begin
               $error("cycle_length: expected none, got %0d", rsp_cycle_length);
               error_count++;
            end else begin
               want_length = expected_lengths.pop_front();
               if (rsp_cycle_length !== want_length) begin
                  $error("cycle_length: expected %0d, got %0d", want_length, rsp_cycle_length);
                  error_count++;
               end else if (want_length != 0) begin
                  cycle_hits++;
                  if (want_length > longest_hit) longest_hit = want_length;
               end
            end
         end
         word_taken <= start && !busy;
         if (start && !busy) begin
            words_taken++;
            if (req_cmd == CMD_LOAD) begin
               loaded_ends[req_edge_index] = {req_end_b, req_end_a};
               load_count++;
            end else begin
               expected_lengths.push_back(single_cycle_length(req_edge_set));
               query_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [63:0] ring;
      logic [63:0] last_ring;
      logic [5:0]  ring_slot;
      logic [5:0]  a;
      int          len;
      int          pick;
      int          base;
      last_ring = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // triangle on the extreme slots and vertices
      plan_load(0, 0, 63);
      plan_load(63, 63, 5);
      plan_load(1, 5, 0);
      plan_query(64'h8000_0000_0000_0003);
      // open path from the triangle, and the empty subset
      plan_query(64'h8000_0000_0000_0001);
      plan_query(64'h0);
      // self-loop in the subset
      plan_load(2, 7, 7);
      plan_query(64'h8000_0000_0000_0007);
      // parallel edge beside the triangle
      plan_load(3, 0, 63);
      plan_query(64'h8000_0000_0000_000B);
      // open path, degree one at both ends
      plan_load(4, 5, 9);
      plan_query(64'h8000_0000_0000_0011);
      // two disjoint triangles, then the second alone
      plan_load(5, 10, 11);
      plan_load(6, 11, 12);
      plan_load(7, 12, 10);
      plan_query(64'h8000_0000_0000_00E3);
      plan_query(64'h0000_0000_0000_00E0);
      // square with mixed orientation
      plan_load(8, 20, 21);
      plan_load(9, 22, 21);
      plan_load(10, 22, 23);
      plan_load(11, 20, 23);
      plan_query(64'h0000_0000_0000_0F00);
      // figure eight, degree four at vertex 0
      plan_load(12, 0, 30);
      plan_load(13, 30, 31);
      plan_load(14, 31, 0);
      plan_query(64'h8000_0000_0000_7003);

      // sender waits until every length is back
      while (words_taken < words_planned || expected_lengths.size() != 0) @(posedge clock);

      base = words_planned;
      while (words_planned < base + RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            // ring with random content, mostly short
            if ($urandom_range(0, 39) == 0)
               len = N_SLOTS;
            else if ($urandom_range(0, 11) == 0)
               len = $urandom_range(9, N_SLOTS - 1);
            else
               len = $urandom_range(3, 8);
            plan_ring(len, ring, ring_slot);
            case ($urandom_range(0, 9))
               6: ring[ring_slot] = 1'b0;
               7: ring |= last_ring;
               8: ring[$urandom_range(0, N_SLOTS - 1)] = 1'b1;
               9: begin
                  // spoil one ring edge, sometimes into a self-loop
                  a = 6'($urandom);
                  plan_load(ring_slot, a, ($urandom_range(0, 1) == 1) ? a : 6'($urandom));
               end
               default: ;
            endcase
            plan_query(ring);
            last_ring = ring;
         end else if (pick <= 7) begin
            // stray loads, some of them self-loops
            repeat ($urandom_range(1, 4)) begin
               a = 6'($urandom);
               plan_load(6'($urandom), a, ($urandom_range(0, 2) == 0) ? a : 6'($urandom));
            end
         end else begin
            // dense or sparse random subset
            if ($urandom_range(0, 1) == 1)
               plan_query({$urandom, $urandom});
            else
               plan_query({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
         end
      end
      calm_mark = words_planned - CALM_WORDS;

      while (words_taken < words_planned || expected_lengths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d load words and %0d queries", load_count, query_count);
      $display("%0d queries formed a single cycle, longest %0d edges", cycle_hits, longest_hit);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
